/* src/pfrm_pkg.sv */
// Shared types and constants of the packet filter rule match block.
package pfrm_pkg;

    // Range slots that fit in one 64-bit port range register.
    localparam int SlotsInReg = 2;
    localparam int PortRangesDef = 2;

    localparam logic [7:0] ProtoAny = 8'hff;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 64;

    localparam logic [CfgIdxW-1:0] RegRulePresent = 3'd0;
    localparam logic [CfgIdxW-1:0] RegDirProto = 3'd1;
    localparam logic [CfgIdxW-1:0] RegSrcAddr = 3'd2;
    localparam logic [CfgIdxW-1:0] RegSrcMask = 3'd3;
    localparam logic [CfgIdxW-1:0] RegDstAddr = 3'd4;
    localparam logic [CfgIdxW-1:0] RegDstMask = 3'd5;
    localparam logic [CfgIdxW-1:0] RegSrcRanges = 3'd6;
    localparam logic [CfgIdxW-1:0] RegDstRanges = 3'd7;

    localparam logic [15:0] DirProtoRst = 16'h00ff;
    localparam logic [63:0] RangesRst = 64'h0000_ffff_0000_ffff;

    typedef struct packed {
        logic        present;
        logic [7:0]  dir;
        logic [7:0]  proto;
        logic [31:0] src_addr;
        logic [31:0] src_mask;
        logic [31:0] dst_addr;
        logic [31:0] dst_mask;
        logic [63:0] src_ranges;
        logic [63:0] dst_ranges;
        logic [SlotsInReg-1:0] src_used;
        logic [SlotsInReg-1:0] dst_used;
    } rule_t;

    // Packet fields as they enter the pipeline.
    typedef struct packed {
        logic [7:0]  direction;
        logic        header_present;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic        ports_present;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } pkt_t;

    // Results of the first compare stage.
    typedef struct packed {
        logic        header_present;
        logic        ports_present;
        logic        dir_proto_ok;
        logic [31:0] src_diff;
        logic [31:0] dst_diff;
        logic [SlotsInReg-1:0] src_hit;
        logic [SlotsInReg-1:0] dst_hit;
    } cmp_t;

    // Results of the reduction stage.
    typedef struct packed {
        logic header_present;
        logic fields_ok;
    } red_t;

    function automatic logic [15:0] slot_start(input logic [63:0] ranges, input int k);
        slot_start = ranges[32*k+16 +: 16];
    endfunction

    function automatic logic [15:0] slot_end(input logic [63:0] ranges, input int k);
        slot_end = ranges[32*k +: 16];
    endfunction

endpackage

/* src/packet_filter_rule_match.sv */
// Top level of the packet filter rule match pipeline with its output register.
//
//   Channel   Direction  Handshake            Payload
//   s_*       in         s_tvalid / s_tready  s_tdata packet fields, s_tuser presence flags
//   m_*       out        m_tvalid / m_tready  m_tdata verdict
//   cfg_*     in         cfg_wr_en            cfg_index, cfg_wr_data
//
// An item passes from acceptance to m_tvalid through the compare stage, reduce
// stage and output register, and one item can enter every cycle while m_tready is high.
// Each stage holds its item while the stage after it is full and stalled, so
// bubbles are squeezed out and nothing is dropped or repeated.
// Reset empties the pipeline and loads the rule registers with their defaults.
module packet_filter_rule_match #(
    parameter int PORT_RANGES = pfrm_pkg::PortRangesDef
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [pfrm_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [pfrm_pkg::CfgDataW-1:0] cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pkt_direction[7:0], pkt_protocol[15:8], pkt_src_addr[47:16],
    // pkt_dst_addr[79:48], pkt_src_port[95:80], pkt_dst_port[111:96]
    input  logic [111:0]                  s_tdata,
    // header_present[0], ports_present[1]
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // matched[0], zeros above
    output logic [7:0]                    m_tdata
);

    pfrm_pkg::rule_t rule;
    pfrm_pkg::pkt_t  pkt;
    pfrm_pkg::cmp_t  cmp;
    pfrm_pkg::red_t  red;
    logic            cmp_valid;
    logic            cmp_ready;
    logic            red_valid;
    logic            red_ready;
    logic            out_valid_reg;
    logic            matched_reg;
    logic            matched_next;

    pfrm_cfg #(
        .PORT_RANGES (PORT_RANGES)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .rule        (rule)
    );

    always_comb begin
        pkt.direction      = s_tdata[7:0];
        pkt.header_present = s_tuser[0];
        pkt.protocol       = s_tdata[15:8];
        pkt.src_addr       = s_tdata[47:16];
        pkt.dst_addr       = s_tdata[79:48];
        pkt.ports_present  = s_tuser[1];
        pkt.src_port       = s_tdata[95:80];
        pkt.dst_port       = s_tdata[111:96];
    end

    pfrm_cmp u_cmp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rule      (rule),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pkt    (pkt),
        .out_valid (cmp_valid),
        .out_ready (cmp_ready),
        .out_cmp   (cmp)
    );

    pfrm_reduce u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rule      (rule),
        .in_valid  (cmp_valid),
        .in_ready  (cmp_ready),
        .in_cmp    (cmp),
        .out_valid (red_valid),
        .out_ready (red_ready),
        .out_red   (red)
    );

    assign red_ready = !out_valid_reg || m_tready;

    // Without a header nothing matches; without a rule every headed packet does.
    assign matched_next = red.header_present && (!rule.present || red.fields_ok);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (red_ready) begin
            out_valid_reg <= red_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (red_valid && red_ready) begin
            matched_reg <= matched_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, matched_reg};

endmodule

/* src/pfrm_cfg.sv */
// Rule register file with the per-slot used flags derived from the range registers.
module pfrm_cfg #(
    parameter int PORT_RANGES = pfrm_pkg::PortRangesDef
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [pfrm_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [pfrm_pkg::CfgDataW-1:0] cfg_wr_data,
    output pfrm_pkg::rule_t              rule
);

    localparam int NumSlots = (PORT_RANGES < pfrm_pkg::SlotsInReg) ?
                              PORT_RANGES : pfrm_pkg::SlotsInReg;

    logic        present_reg;
    logic [15:0] dir_proto_reg;
    logic [31:0] src_addr_reg;
    logic [31:0] src_mask_reg;
    logic [31:0] dst_addr_reg;
    logic [31:0] dst_mask_reg;
    logic [63:0] src_ranges_reg;
    logic [63:0] dst_ranges_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg    <= 1'b0;
            dir_proto_reg  <= pfrm_pkg::DirProtoRst;
            src_addr_reg   <= '0;
            src_mask_reg   <= '0;
            dst_addr_reg   <= '0;
            dst_mask_reg   <= '0;
            src_ranges_reg <= pfrm_pkg::RangesRst;
            dst_ranges_reg <= pfrm_pkg::RangesRst;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pfrm_pkg::RegRulePresent: present_reg    <= cfg_wr_data[0];
                pfrm_pkg::RegDirProto:    dir_proto_reg  <= cfg_wr_data[15:0];
                pfrm_pkg::RegSrcAddr:     src_addr_reg   <= cfg_wr_data[31:0];
                pfrm_pkg::RegSrcMask:     src_mask_reg   <= cfg_wr_data[31:0];
                pfrm_pkg::RegDstAddr:     dst_addr_reg   <= cfg_wr_data[31:0];
                pfrm_pkg::RegDstMask:     dst_mask_reg   <= cfg_wr_data[31:0];
                pfrm_pkg::RegSrcRanges:   src_ranges_reg <= cfg_wr_data;
                pfrm_pkg::RegDstRanges:   dst_ranges_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        rule.present    = present_reg;
        rule.dir        = dir_proto_reg[15:8];
        rule.proto      = dir_proto_reg[7:0];
        rule.src_addr   = src_addr_reg;
        rule.src_mask   = src_mask_reg;
        rule.dst_addr   = dst_addr_reg;
        rule.dst_mask   = dst_mask_reg;
        rule.src_ranges = src_ranges_reg;
        rule.dst_ranges = dst_ranges_reg;
        // A slot beyond the configured count, or with start above end, is unused.
        for (int k = 0; k < pfrm_pkg::SlotsInReg; k++) begin
            rule.src_used[k] = (k < NumSlots) &&
                (pfrm_pkg::slot_start(src_ranges_reg, k) <=
                 pfrm_pkg::slot_end(src_ranges_reg, k));
            rule.dst_used[k] = (k < NumSlots) &&
                (pfrm_pkg::slot_start(dst_ranges_reg, k) <=
                 pfrm_pkg::slot_end(dst_ranges_reg, k));
        end
    end

endmodule

/* src/pfrm_cmp.sv */
// First pipeline stage: field compares against the rule and port range compares.
module pfrm_cmp (
    input  logic            aclk,
    input  logic            aresetn,
    input  pfrm_pkg::rule_t rule,
    input  logic            in_valid,
    output logic            in_ready,
    input  pfrm_pkg::pkt_t  in_pkt,
    output logic            out_valid,
    input  logic            out_ready,
    output pfrm_pkg::cmp_t  out_cmp
);

    logic           valid_reg;
    pfrm_pkg::cmp_t cmp_reg;
    pfrm_pkg::cmp_t cmp_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        cmp_next.header_present = in_pkt.header_present;
        cmp_next.ports_present  = in_pkt.ports_present;
        cmp_next.dir_proto_ok   = (rule.dir == in_pkt.direction) &&
                                  ((rule.proto == pfrm_pkg::ProtoAny) ||
                                   (rule.proto == in_pkt.protocol));
        cmp_next.src_diff = (in_pkt.src_addr ^ rule.src_addr) & rule.src_mask;
        cmp_next.dst_diff = (in_pkt.dst_addr ^ rule.dst_addr) & rule.dst_mask;
        for (int k = 0; k < pfrm_pkg::SlotsInReg; k++) begin
            cmp_next.src_hit[k] = rule.src_used[k] &&
                (pfrm_pkg::slot_start(rule.src_ranges, k) <= in_pkt.src_port) &&
                (in_pkt.src_port <= pfrm_pkg::slot_end(rule.src_ranges, k));
            cmp_next.dst_hit[k] = rule.dst_used[k] &&
                (pfrm_pkg::slot_start(rule.dst_ranges, k) <= in_pkt.dst_port) &&
                (in_pkt.dst_port <= pfrm_pkg::slot_end(rule.dst_ranges, k));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            cmp_reg <= cmp_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_cmp   = cmp_reg;

endmodule

/* src/pfrm_reduce.sv */
// Second pipeline stage: reduces address differences and port hits to one verdict.
module pfrm_reduce (
    input  logic            aclk,
    input  logic            aresetn,
    input  pfrm_pkg::rule_t rule,
    input  logic            in_valid,
    output logic            in_ready,
    input  pfrm_pkg::cmp_t  in_cmp,
    output logic            out_valid,
    input  logic            out_ready,
    output pfrm_pkg::red_t  out_red
);

    logic           valid_reg;
    pfrm_pkg::red_t red_reg;
    pfrm_pkg::red_t red_next;
    logic           src_port_ok;
    logic           dst_port_ok;
    logic           ports_needed;
    logic           ports_ok;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        // An empty range list accepts any port.
        src_port_ok  = !(|rule.src_used) || (|in_cmp.src_hit);
        dst_port_ok  = !(|rule.dst_used) || (|in_cmp.dst_hit);
        ports_needed = (|rule.src_used) || (|rule.dst_used);
        ports_ok     = !ports_needed ||
                       (in_cmp.ports_present && src_port_ok && dst_port_ok);
        red_next.header_present = in_cmp.header_present;
        red_next.fields_ok      = in_cmp.dir_proto_ok && !(|in_cmp.src_diff) &&
                                  !(|in_cmp.dst_diff) && ports_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            red_reg <= red_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_red   = red_reg;

endmodule
